@@ src/slod_pkg.sv @@
// Shared types and constants of the scenery level-of-detail selector.
`default_nettype none
package slod_pkg;

   localparam logic [1:0] FUNC_WRITE_THR = 2'd0;
   localparam logic [1:0] FUNC_SET_LEN   = 2'd1;
   localparam logic [1:0] FUNC_QUERY     = 2'd2;

   localparam logic [31:0] VIEW_DIVIDEND = 32'd655360;
   localparam logic [16:0] DEFAULT_DIV   = 17'd4096;
   localparam logic [15:0] PROJ_RESET    = 16'd256;

   typedef enum logic [1:0] {
      OP_THR,
      OP_LEN,
      OP_QUERY,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               list_ok;
      logic               entry_ok;
      logic [5:0]         list_index;
      logic [3:0]         entry_index;
      logic [31:0]        thr_sq;
      logic [4:0]         count;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic [15:0]        div;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_VIEW,
      ST_DIV_K,
      ST_SQUARE,
      ST_MUL1,
      ST_MUL2,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

@@ src/slod_front.sv @@
// Front end: decodes an incoming word into a command for the queue.
`default_nettype none
module slod_front #(
   parameter int LIST_COUNT       = 64,
   parameter int ENTRIES_PER_LIST = 16
) (
   input  wire logic [1:0]  func,
   input  wire logic [5:0]  list_index,
   input  wire logic [3:0]  entry_index,
   input  wire logic [31:0] threshold_word,
   input  wire logic [4:0]  entry_count,
   input  wire logic [31:0] cam_x,
   input  wire logic [31:0] cam_y,
   input  wire logic [31:0] cam_z,
   input  wire logic [15:0] lod_divisor,
   output slod_pkg::cmd_type cmd
);
   logic [17:0] thr_root;
   logic [35:0] thr_root_sq;

   assign thr_root    = threshold_word[31:14];
   assign thr_root_sq = thr_root * thr_root;

   always_comb begin
      cmd.op = slod_pkg::OP_NONE;
      case (func)
         slod_pkg::FUNC_WRITE_THR: cmd.op = slod_pkg::OP_THR;
         slod_pkg::FUNC_SET_LEN:   cmd.op = slod_pkg::OP_LEN;
         slod_pkg::FUNC_QUERY:     cmd.op = slod_pkg::OP_QUERY;
         default:                  cmd.op = slod_pkg::OP_NONE;
      endcase
      cmd.list_ok     = 32'(list_index) < 32'(LIST_COUNT);
      cmd.entry_ok    = 32'(entry_index) < 32'(ENTRIES_PER_LIST);
      cmd.list_index  = list_index;
      cmd.entry_index = entry_index;
      cmd.thr_sq      = thr_root_sq[31:0];
      cmd.count       = (32'(entry_count) > 32'(ENTRIES_PER_LIST)) ?
                        5'(ENTRIES_PER_LIST) : entry_count;
      cmd.qx          = cam_x[29:14];
      cmd.qy          = cam_y[29:14];
      cmd.qz          = cam_z[29:14];
      cmd.div         = lod_divisor;
   end
endmodule
`default_nettype wire

@@ src/slod_queue.sv @@
// Two-entry command queue between the front and back ends.
`default_nettype none
module slod_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  slod_pkg::cmd_type      push_cmd,
   input  wire logic              pop,
   output slod_pkg::cmd_type      head_cmd,
   output logic                   empty,
   output logic                   full
);
   slod_pkg::cmd_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] level_ff, level_in;

   assign empty    = level_ff == 2'd0;
   assign full     = level_ff == 2'd2;
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule
`default_nettype wire

@@ src/slod_back.sv @@
// Back end: tables, serial divider, multiplies, threshold walk and result register.
`default_nettype none
module slod_back #(
   parameter int LIST_COUNT       = 64,
   parameter int ENTRIES_PER_LIST = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [15:0]  proj_dist,
   input  slod_pkg::cmd_type head_cmd,
   input  wire logic         q_empty,
   output logic              pop,
   output logic              clearing,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              lod_found,
   output logic [3:0]        lod_index,
   output logic [31:0]       distance_measure
);
   localparam int LW    = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
   localparam int DEPTH = LIST_COUNT * ENTRIES_PER_LIST;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [31:0] thr_mem [DEPTH];
   logic [4:0]  len_mem [LIST_COUNT];

   slod_pkg::state_type state_ff, state_in;
   slod_pkg::cmd_type   cmd_ff;
   logic [LW-1:0] clr_idx_ff;
   logic [4:0]    cnt_ff;
   logic [16:0]   rem_ff;
   logic [31:0]   quo_ff;
   logic [31:0]   k_ff, sum_ff, s1_ff, m_ff;
   logic          found_ff;
   logic [3:0]    idx_ff;
   logic [4:0]    len_rd_ff;
   logic [31:0]   thr_rd_ff;
   logic          rsp_valid_ff;
   logic          rsp_found_ff;
   logic [3:0]    rsp_index_ff;
   logic [31:0]   rsp_measure_ff;

   logic          out_load;
   logic          thr_we, len_we;
   logic [16:0]   divisor;
   logic [17:0]   rem_sh;
   logic          ge;
   logic [16:0]   rem_nx;
   logic [31:0]   q_nx;
   logic [15:0]   h;
   logic [16:0]   mag;
   logic          neg;
   logic signed [15:0] qsel;
   logic signed [31:0] sq;
   logic signed [63:0] p1;
   logic signed [65:0] p2;
   logic [31:0]   waddr_w, raddr_w, hlist_w, clist_w;
   logic          last_entry;

   assign h    = (proj_dist == 16'd0) ? 16'd1 : proj_dist;
   assign neg  = cmd_ff.div[15];
   assign mag  = (cmd_ff.div == 16'd0) ? slod_pkg::DEFAULT_DIV :
                 (neg ? 17'h10000 - {1'b0, cmd_ff.div} : {1'b0, cmd_ff.div});
   assign divisor = (state_ff == slod_pkg::ST_DIV_VIEW) ? {1'b0, h} : mag;
   assign rem_sh  = {rem_ff, quo_ff[31]};
   assign ge      = rem_sh >= {1'b0, divisor};
   assign rem_nx  = ge ? 17'(rem_sh - {1'b0, divisor}) : rem_sh[16:0];
   assign q_nx    = {quo_ff[30:0], ge};

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    qsel = cmd_ff.qx;
         2'd1:    qsel = cmd_ff.qy;
         default: qsel = cmd_ff.qz;
      endcase
   end
   assign sq = qsel * qsel;
   assign p1 = $signed(sum_ff) * $signed(k_ff);
   assign p2 = $signed({1'b0, s1_ff}) * $signed({k_ff[31], k_ff});

   assign hlist_w = 32'(head_cmd.list_index);
   assign clist_w = 32'(cmd_ff.list_index);
   assign waddr_w = hlist_w * 32'(ENTRIES_PER_LIST) + 32'(head_cmd.entry_index);
   assign raddr_w = clist_w * 32'(ENTRIES_PER_LIST) + 32'(idx_ff);
   assign last_entry = (5'(idx_ff) + 5'd1) == len_rd_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slod_pkg::ST_CLEAR:
            if (clr_idx_ff == LW'(LIST_COUNT - 1)) state_in = slod_pkg::ST_IDLE;
         slod_pkg::ST_IDLE:
            if (!q_empty) begin
               state_in = (head_cmd.op == slod_pkg::OP_QUERY) ?
                          slod_pkg::ST_DIV_VIEW : slod_pkg::ST_DONE;
            end
         slod_pkg::ST_DIV_VIEW:
            if (cnt_ff == 5'd31) state_in = slod_pkg::ST_DIV_K;
         slod_pkg::ST_DIV_K:
            if (cnt_ff == 5'd31) state_in = slod_pkg::ST_SQUARE;
         slod_pkg::ST_SQUARE:
            if (cnt_ff == 5'd2) state_in = slod_pkg::ST_MUL1;
         slod_pkg::ST_MUL1:
            state_in = slod_pkg::ST_MUL2;
         slod_pkg::ST_MUL2:
            state_in = (cmd_ff.list_ok && len_rd_ff != 5'd0) ?
                       slod_pkg::ST_WALK_RD : slod_pkg::ST_DONE;
         slod_pkg::ST_WALK_RD:
            state_in = slod_pkg::ST_WALK_CMP;
         slod_pkg::ST_WALK_CMP:
            state_in = (thr_rd_ff > m_ff || last_entry) ?
                       slod_pkg::ST_DONE : slod_pkg::ST_WALK_RD;
         slod_pkg::ST_DONE:
            if (!rsp_valid_ff || !rsp_stall) state_in = slod_pkg::ST_IDLE;
         default:
            state_in = slod_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      clearing = state_ff == slod_pkg::ST_CLEAR;
      pop      = state_ff == slod_pkg::ST_IDLE && !q_empty;
      out_load = state_ff == slod_pkg::ST_DONE && (!rsp_valid_ff || !rsp_stall);
      thr_we   = pop && head_cmd.op == slod_pkg::OP_THR &&
                 head_cmd.list_ok && head_cmd.entry_ok;
      len_we   = pop && head_cmd.op == slod_pkg::OP_LEN && head_cmd.list_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slod_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_idx_ff <= clr_idx_ff + LW'(1);
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         len_mem[clr_idx_ff] <= 5'd0;
      end else if (len_we) begin
         len_mem[hlist_w[LW-1:0]] <= head_cmd.count;
      end
      len_rd_ff <= len_mem[clist_w[LW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (thr_we) begin
         thr_mem[waddr_w[AW-1:0]] <= head_cmd.thr_sq;
      end
      thr_rd_ff <= thr_mem[raddr_w[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         slod_pkg::ST_IDLE: begin
            cmd_ff   <= head_cmd;
            cnt_ff   <= 5'd0;
            rem_ff   <= 17'd0;
            quo_ff   <= slod_pkg::VIEW_DIVIDEND;
            sum_ff   <= 32'd0;
            m_ff     <= 32'd0;
            found_ff <= 1'b0;
            idx_ff   <= 4'd0;
         end
         slod_pkg::ST_DIV_VIEW: begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               rem_ff <= 17'd0;
               quo_ff <= {q_nx[19:0], 12'd0};
            end else begin
               rem_ff <= rem_nx;
               quo_ff <= q_nx;
            end
         end
         slod_pkg::ST_DIV_K: begin
            cnt_ff <= cnt_ff + 5'd1;
            rem_ff <= rem_nx;
            quo_ff <= q_nx;
            if (cnt_ff == 5'd31) k_ff <= neg ? 32'd0 - q_nx : q_nx;
         end
         slod_pkg::ST_SQUARE: begin
            cnt_ff <= cnt_ff + 5'd1;
            sum_ff <= sum_ff + sq;
         end
         slod_pkg::ST_MUL1: s1_ff <= p1[43:12];
         slod_pkg::ST_MUL2: m_ff  <= p2[43:12];
         slod_pkg::ST_WALK_CMP: begin
            if (thr_rd_ff > m_ff) begin
               found_ff <= 1'b1;
            end else if (!last_entry) begin
               idx_ff <= idx_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase
      if (out_load) begin
         rsp_found_ff   <= found_ff;
         rsp_index_ff   <= found_ff ? idx_ff : 4'd0;
         rsp_measure_ff <= m_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign lod_found        = rsp_found_ff;
   assign lod_index        = rsp_index_ff;
   assign distance_measure = rsp_measure_ff;
endmodule
`default_nettype wire

@@ src/scenery_lod_selector.sv @@
// Top level of the scenery level-of-detail selector.
// A write or an unused function code goes from acceptance through the done
// state to its result; a query runs the one-bit-per-cycle divider twice and,
// after the squares and multiplies, reads and compares the thresholds of its
// list one entry at a time. After reset the entry counts of all LIST_COUNT
// lists are cleared, during which no word is accepted. A two-word queue lets
// new words in while a result waits to be taken.
`default_nettype none
module scenery_lod_selector #(
   parameter int LIST_COUNT       = 64,
   parameter int ENTRIES_PER_LIST = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_projection_distance,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [5:0]  req_list_index,
   input  wire logic [3:0]  req_entry_index,
   input  wire logic [31:0] req_threshold_word,
   input  wire logic [4:0]  req_entry_count,
   input  wire logic signed [31:0] req_cam_x,
   input  wire logic signed [31:0] req_cam_y,
   input  wire logic signed [31:0] req_cam_z,
   input  wire logic signed [15:0] req_lod_divisor,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_lod_found,
   output logic [3:0]       rsp_lod_index,
   output logic [31:0]      rsp_distance_measure
);
   logic [15:0] proj_ff;
   slod_pkg::cmd_type front_cmd, head_cmd;
   logic push, pop, q_empty, q_full, clearing;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         proj_ff <= slod_pkg::PROJ_RESET;
      end else if (csr_valid && csr_ready) begin
         proj_ff <= csr_projection_distance;
      end
   end

   assign req_stall = q_full || clearing;
   assign push      = req_valid && !req_stall;

   slod_front #(
      .LIST_COUNT(LIST_COUNT),
      .ENTRIES_PER_LIST(ENTRIES_PER_LIST)
   ) u_front (
      .func(req_func),
      .list_index(req_list_index),
      .entry_index(req_entry_index),
      .threshold_word(req_threshold_word),
      .entry_count(req_entry_count),
      .cam_x(req_cam_x),
      .cam_y(req_cam_y),
      .cam_z(req_cam_z),
      .lod_divisor(req_lod_divisor),
      .cmd(front_cmd)
   );

   slod_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(front_cmd),
      .pop(pop),
      .head_cmd(head_cmd),
      .empty(q_empty),
      .full(q_full)
   );

   slod_back #(
      .LIST_COUNT(LIST_COUNT),
      .ENTRIES_PER_LIST(ENTRIES_PER_LIST)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .proj_dist(proj_ff),
      .head_cmd(head_cmd),
      .q_empty(q_empty),
      .pop(pop),
      .clearing(clearing),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .lod_found(rsp_lod_found),
      .lod_index(rsp_lod_index),
      .distance_measure(rsp_distance_measure)
   );
endmodule
`default_nettype wire
